[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/jcsp_pkg.sv]
// ----------------------------------------------------------------------------
// jcsp_pkg
// Types, codes and helpers shared by the JTAG command stream parser.
// ----------------------------------------------------------------------------
package jcsp_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_PULSE = 2'd0;
    localparam logic [1:0] KIND_DELAY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPCODE_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPCODE_MULTI = 1'b1;
    localparam logic [7:0] OPCODE_DELAY_RST = 8'd1;
    localparam logic [7:0] OPCODE_MULTI_RST = 8'd2;

    // Delay flag byte bits.
    localparam int DLY_TMS_BIT  = 0;
    localparam int DLY_TCK_BIT  = 1;
    localparam int DLY_USEC_BIT = 2;

    // Delay count selection, taken from the TCK and microsecond flag bits.
    localparam logic [1:0] SEL_NONE = 2'b00;
    localparam logic [1:0] SEL_TCK  = 2'b01;
    localparam logic [1:0] SEL_USEC = 2'b10;
    localparam logic [1:0] SEL_BOTH = 2'b11;

    // Pulse byte bits.
    localparam int PLS_TMS_BIT    = 0;
    localparam int PLS_TDI_BIT    = 1;
    localparam int PLS_CHECK_BIT  = 2;
    localparam int PLS_EXPECT_BIT = 3;
    localparam int PLS_MARK_BIT   = 7;

    localparam logic [3:0] IDX_MAX        = 4'd15;
    localparam logic [3:0] IDX_FIRST_WORD = 4'd4;
    localparam logic [3:0] IDX_LAST_WORD  = 4'd8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One classified stream item.
    typedef struct packed {
        logic       restart;
        logic       repeat_mark;  // Bit 7 clear: may be a repeat count.
        logic [7:0] data;
    } t_item;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef struct packed {
        logic [1:0]  kind;
        logic        tms;
        logic        tdi;
        logic        tdo_check;
        logic        tdo_expect;
        logic [6:0]  repeat_res;
        logic [31:0] tck_count;
        logic [31:0] usec_count;
    } t_result;

    // Places one byte into one byte lane of a 32-bit word.
    function automatic logic [31:0] put_byte(input logic [31:0] word,
                                             input logic [1:0]  lane,
                                             input logic [7:0]  value);
        logic [31:0] res;
        res = word;
        for (int i = 0; i < 4; i++) begin
            if (lane == 2'(i)) begin
                res[8*i +: 8] = value;
            end
        end
        return res;
    endfunction

endpackage

[rtl/core/jcsp_front.sv]
// ----------------------------------------------------------------------------
// jcsp_front
// Accepts stream requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module jcsp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_action,
    input  logic [7:0]           i_data,
    input  logic                 i_pop,
    output jcsp_pkg::t_queue_head o_head
);

    jcsp_pkg::t_item                       r_mem [jcsp_pkg::QUEUE_DEPTH];
    logic [jcsp_pkg::QUEUE_PTR_W-1:0]      r_wr_ptr;
    logic [jcsp_pkg::QUEUE_PTR_W-1:0]      r_rd_ptr;
    logic [jcsp_pkg::QUEUE_CNT_W-1:0]      r_count;
    logic [jcsp_pkg::QUEUE_CNT_W-1:0]      n_count;
    jcsp_pkg::t_item                       w_item;
    logic                                  w_push;
    logic                                  w_pop;

    assign o_in_stall = (r_count == jcsp_pkg::QUEUE_CNT_W'(jcsp_pkg::QUEUE_DEPTH));
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_pop && (r_count != '0);

    always_comb begin
        w_item.restart     = i_action;
        w_item.repeat_mark = !i_data[jcsp_pkg::PLS_MARK_BIT];
        w_item.data        = i_data;
    end

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

[rtl/core/jcsp_exec.sv]
// ----------------------------------------------------------------------------
// jcsp_exec
// Parser state machine: runs queued bytes and registers the pin operations.
// ----------------------------------------------------------------------------
module jcsp_exec (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [jcsp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    input  jcsp_pkg::t_queue_head               i_head,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output jcsp_pkg::t_result                   o_result
);

    logic [7:0]        r_op_delay;
    logic [7:0]        r_op_multi;

    logic [7:0]        r_cmd,      n_cmd;
    logic [3:0]        r_idx,      n_idx;
    logic [2:0]        r_flags,    n_flags;
    logic [31:0]       r_tck,      n_tck;
    logic [31:0]       r_usec,     n_usec;
    logic [15:0]       r_total,    n_total;
    logic [16:0]       r_done,     n_done;
    logic [6:0]        r_pend,     n_pend;

    logic              r_out_valid;
    jcsp_pkg::t_result r_result;
    jcsp_pkg::t_result w_res;
    logic              w_has_res;
    logic [3:0]        w_idx_inc;
    logic [1:0]        w_sel;
    logic              w_delay_done;
    logic [6:0]        w_cnt;
    logic [7:0]        w_b;
    logic              w_can_take;

    assign w_can_take = !r_out_valid || !i_out_stall;
    assign o_pop      = i_head.valid && w_can_take;
    assign w_b        = i_head.item.data;
    assign w_idx_inc  = (r_idx == jcsp_pkg::IDX_MAX) ? r_idx : r_idx + 4'd1;

    always_comb begin
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_flags      = r_flags;
        n_tck        = r_tck;
        n_usec       = r_usec;
        n_total      = r_total;
        n_done       = r_done;
        n_pend       = r_pend;
        w_res        = '0;
        w_has_res    = 1'b0;
        w_sel        = '0;
        w_delay_done = 1'b0;
        w_cnt        = '0;

        if (i_head.item.restart) begin
            n_cmd   = '0;
            n_idx   = '0;
            n_flags = '0;
            n_tck   = '0;
            n_usec  = '0;
            n_total = '0;
            n_done  = '0;
            n_pend  = '0;
        end else if (r_cmd == '0) begin
            n_cmd = w_b;
            n_idx = '0;
        end else if (r_cmd == r_op_delay) begin
            n_idx = w_idx_inc;
            if (r_idx == '0) begin
                n_flags = w_b[2:0];
                n_tck   = '0;
                n_usec  = '0;
            end else if (r_idx <= jcsp_pkg::IDX_FIRST_WORD) begin
                if (r_flags[jcsp_pkg::DLY_TCK_BIT]) begin
                    n_tck = jcsp_pkg::put_byte(r_tck, 2'(r_idx - 4'd1), w_b);
                end else begin
                    n_usec = jcsp_pkg::put_byte(r_usec, 2'(r_idx - 4'd1), w_b);
                end
            end else if (r_idx <= jcsp_pkg::IDX_LAST_WORD) begin
                n_usec = jcsp_pkg::put_byte(r_usec, 2'(r_idx - 4'd5), w_b);
            end
            w_sel = {n_flags[jcsp_pkg::DLY_USEC_BIT], n_flags[jcsp_pkg::DLY_TCK_BIT]};
            unique case (w_sel) inside
                jcsp_pkg::SEL_NONE: begin
                    w_delay_done = 1'b1;
                end
                jcsp_pkg::SEL_TCK, jcsp_pkg::SEL_USEC: begin
                    w_delay_done = (r_idx == jcsp_pkg::IDX_FIRST_WORD);
                end
                jcsp_pkg::SEL_BOTH: begin
                    w_delay_done = (r_idx == jcsp_pkg::IDX_LAST_WORD);
                end
                default: begin
                    w_delay_done = 1'b0;
                end
            endcase
            if (w_delay_done) begin
                w_has_res      = 1'b1;
                w_res.kind     = jcsp_pkg::KIND_DELAY;
                w_res.tms      = n_flags[jcsp_pkg::DLY_TMS_BIT];
                w_res.tck_count  = n_tck;
                w_res.usec_count = n_usec;
                n_cmd          = '0;
            end
        end else if (r_cmd == r_op_multi) begin
            n_idx = w_idx_inc;
            if (r_idx == 4'd0) begin
                n_total = {8'd0, w_b};
                n_done  = '0;
                n_pend  = '0;
            end else if (r_idx == 4'd1) begin
                n_total = {w_b, r_total[7:0]};
            end else begin
                if (r_pend == '0 && i_head.item.repeat_mark) begin
                    n_pend = w_b[6:0];
                end else begin
                    w_cnt            = (r_pend != '0) ? r_pend : 7'd1;
                    w_has_res        = 1'b1;
                    w_res.kind       = jcsp_pkg::KIND_PULSE;
                    w_res.tms        = w_b[jcsp_pkg::PLS_TMS_BIT];
                    w_res.tdi        = w_b[jcsp_pkg::PLS_TDI_BIT];
                    w_res.tdo_check  = w_b[jcsp_pkg::PLS_CHECK_BIT];
                    w_res.tdo_expect = w_b[jcsp_pkg::PLS_CHECK_BIT]
                                       & w_b[jcsp_pkg::PLS_EXPECT_BIT];
                    w_res.repeat_res = w_cnt;
                    n_done           = r_done + {10'd0, w_cnt};
                    n_pend           = '0;
                end
                // The command ends once the pulse total is covered.
                if (n_done >= {1'b0, r_total}) begin
                    n_cmd = '0;
                end
            end
        end else begin
            // Unknown command: sticky error, state left alone.
            w_has_res  = 1'b1;
            w_res.kind = jcsp_pkg::KIND_ERROR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_delay <= jcsp_pkg::OPCODE_DELAY_RST;
            r_op_multi <= jcsp_pkg::OPCODE_MULTI_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                jcsp_pkg::CFG_OPCODE_DELAY: r_op_delay <= i_cfg_data;
                jcsp_pkg::CFG_OPCODE_MULTI: r_op_multi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= '0;
            r_idx       <= '0;
            r_flags     <= '0;
            r_tck       <= '0;
            r_usec      <= '0;
            r_total     <= '0;
            r_done      <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cmd   <= n_cmd;
                r_idx   <= n_idx;
                r_flags <= n_flags;
                r_tck   <= n_tck;
                r_usec  <= n_usec;
                r_total <= n_total;
                r_done  <= n_done;
                r_pend  <= n_pend;
            end
            if (w_can_take) begin
                r_out_valid <= o_pop && w_has_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_has_res) begin
            r_result <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

[rtl/core/jtag_command_stream_parser.sv]
// ----------------------------------------------------------------------------
// jtag_command_stream_parser
// Turns a JTAG command byte stream into delay and pulse-group pin operations.
// ----------------------------------------------------------------------------
// An accepted byte is written to a queue entry, and its result is then registered at the output.
// Throughput: one byte per cycle while the output is not stalled and the queue is not empty.
// A two-entry queue separates the input from the parser, and the output is registered.
// Reset (synchronous, active low) clears the queue, the parser state and the
// output valid, and loads the opcode registers with 1 (delay) and 2 (multi-pulse).
module jtag_command_stream_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [jcsp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_action,
    input  logic [7:0]                     i_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_kind,
    output logic                           o_tms,
    output logic                           o_tdi,
    output logic                           o_tdo_check,
    output logic                           o_tdo_expect,
    output logic [6:0]                     o_repeat_res,
    output logic [31:0]                    o_tck_count,
    output logic [31:0]                    o_usec_count
);

    jcsp_pkg::t_queue_head w_head;
    jcsp_pkg::t_result     w_result;
    logic                  w_pop;

    jcsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_action   (i_action),
        .i_data     (i_data),
        .i_pop      (w_pop),
        .o_head     (w_head)
    );

    jcsp_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_result)
    );

    assign o_kind       = w_result.kind;
    assign o_tms        = w_result.tms;
    assign o_tdi        = w_result.tdi;
    assign o_tdo_check  = w_result.tdo_check;
    assign o_tdo_expect = w_result.tdo_expect;
    assign o_repeat_res = w_result.repeat_res;
    assign o_tck_count  = w_result.tck_count;
    assign o_usec_count = w_result.usec_count;

endmodule

[rtl/core/jcsp_checker.sv]
// ----------------------------------------------------------------------------
// jcsp_checker
// Port-level checks of the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jcsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic        o_tms,
    input logic        o_tdi,
    input logic        o_tdo_check,
    input logic        o_tdo_expect,
    input logic [6:0]  o_repeat_res,
    input logic [31:0] o_tck_count,
    input logic [31:0] o_usec_count
);

    // A stalled result stays offered.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // An error carries nothing but its kind.
    `ASSERT_IMPLIES(a_error_clean, i_clk, i_rst_n, o_out_valid && o_kind == jcsp_pkg::KIND_ERROR, !o_tms && !o_tdi && !o_tdo_check && !o_tdo_expect && o_repeat_res == 7'd0 && o_tck_count == 32'd0 && o_usec_count == 32'd0)

    // A pulse group has at least one pulse and no delay counts.
    `ASSERT_IMPLIES(a_pulse_shape, i_clk, i_rst_n, o_out_valid && o_kind == jcsp_pkg::KIND_PULSE, o_repeat_res != 7'd0 && o_tck_count == 32'd0 && o_usec_count == 32'd0)

    // A delay operation drives no pulse fields.
    `ASSERT_IMPLIES(a_delay_shape, i_clk, i_rst_n, o_out_valid && o_kind == jcsp_pkg::KIND_DELAY, !o_tdi && !o_tdo_check && o_repeat_res == 7'd0)

    // An expected TDO level is only given when checking is enabled.
    `ASSERT_IMPLIES(a_expect_needs_check, i_clk, i_rst_n, o_out_valid, !o_tdo_expect || o_tdo_check)

endmodule

bind jtag_command_stream_parser jcsp_checker u_checker (.*);
